@@ src/general_purpose_timer_regs_unit_macros.svh @@
// Assertion macros for the timer register unit's core
`ifndef GENERAL_PURPOSE_TIMER_REGS_UNIT_MACROS_SVH
`define GENERAL_PURPOSE_TIMER_REGS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define GPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define GPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ src/gpt_pkg.sv @@
// Package with command codes, register word map and beat type of the timer unit
package gpt_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Word indexes of the registers with special behavior
	localparam logic [4:0] W_TIDR    = 5'd0;
	localparam logic [4:0] W_TIOCP   = 5'd4;
	localparam logic [4:0] W_IRQRAW  = 5'd9;
	localparam logic [4:0] W_IRQSTAT = 5'd10;
	localparam logic [4:0] W_IENSET  = 5'd11;
	localparam logic [4:0] W_IENCLR  = 5'd12;
	localparam logic [4:0] W_TCLR    = 5'd14;
	localparam logic [4:0] W_TCRR    = 5'd15;
	localparam logic [4:0] W_TLDR    = 5'd16;
	localparam logic [4:0] W_TTGR    = 5'd17;
	localparam logic [4:0] W_TMAR    = 5'd19;

	localparam logic [31:0] REVISION = 32'h4000_0100;
	localparam int unsigned MAX_WORDS = 32;

	// Control register bit positions
	localparam int unsigned CTL_ST  = 0;
	localparam int unsigned CTL_AR  = 1;
	localparam int unsigned CTL_PRE = 5;
	localparam int unsigned CTL_CE  = 6;

	// Status bits
	localparam logic [1:0] IRQ_MAT = 2'b01;
	localparam logic [1:0] IRQ_OVF = 2'b10;

	typedef struct packed {
		cmd_t        cmd;
		logic [4:0]  reg_index;
		logic [31:0] wdata;
	} item_t;

endpackage

@@ src/gpt_in_stage.sv @@
// Input register stage that holds one request beat until the core takes it
module gpt_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [1:0]    cmd,
	input  logic [4:0]    reg_index,
	input  logic [31:0]   wdata,
	input  logic          take,
	output logic          valid_s1,
	output gpt_pkg::item_t item_s1
);

	logic accept;

	// Hold the beat while the core cannot take it
	assign req_stall = valid_s1 && !take;
	assign accept    = req_valid && !req_stall;

	// Track occupancy of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd       <= gpt_pkg::cmd_t'(cmd);
			item_s1.reg_index <= reg_index;
			item_s1.wdata     <= wdata;
		end
	end

endmodule

@@ src/gpt_out_stage.sv @@
// Output register stage that holds one response beat until it is taken
module gpt_out_stage (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [31:0] rdata_d,
	output logic        ready,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] rdata
);

	// Free when empty or when the held beat leaves this cycle
	assign ready = !rsp_valid || !rsp_stall;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	// Capture the read data
	always_ff @(posedge clk) begin
		if (load) begin
			rdata <= rdata_d;
		end
	end

endmodule

@@ src/gpt_core.sv @@
// Register file, prescaler and counter update for one request beat
`include "general_purpose_timer_regs_unit_macros.svh"

module gpt_core #(
	parameter int unsigned REG_WORDS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  gpt_pkg::item_t item_s1,
	output logic [31:0]    rdata_d
);

	// Only words reachable by a 5-bit index are stored
	localparam int unsigned STORE_WORDS =
		(REG_WORDS < gpt_pkg::MAX_WORDS) ? REG_WORDS : gpt_pkg::MAX_WORDS;
	localparam int unsigned IDX_W = $clog2(STORE_WORDS);

	localparam logic [IDX_W-1:0] I_TIDR    = IDX_W'(gpt_pkg::W_TIDR);
	localparam logic [IDX_W-1:0] I_TIOCP   = IDX_W'(gpt_pkg::W_TIOCP);
	localparam logic [IDX_W-1:0] I_IRQRAW  = IDX_W'(gpt_pkg::W_IRQRAW);
	localparam logic [IDX_W-1:0] I_IRQSTAT = IDX_W'(gpt_pkg::W_IRQSTAT);
	localparam logic [IDX_W-1:0] I_IENSET  = IDX_W'(gpt_pkg::W_IENSET);
	localparam logic [IDX_W-1:0] I_TCLR    = IDX_W'(gpt_pkg::W_TCLR);
	localparam logic [IDX_W-1:0] I_TCRR    = IDX_W'(gpt_pkg::W_TCRR);
	localparam logic [IDX_W-1:0] I_TLDR    = IDX_W'(gpt_pkg::W_TLDR);
	localparam logic [IDX_W-1:0] I_TMAR    = IDX_W'(gpt_pkg::W_TMAR);

	logic [31:0]      regs_q [STORE_WORDS];
	logic [31:0]      regs_d [STORE_WORDS];
	logic             run_q;
	logic             run_d;
	logic [3:0]       shift_q;
	logic [3:0]       shift_d;
	logic [7:0]       count_q;
	logic [7:0]       count_d;

	logic [IDX_W-1:0] idx;
	logic             in_range;
	logic [31:0]      wv;
	logic [31:0]      ctl;
	logic [31:0]      tcrr;
	logic [31:0]      tldr;
	logic [31:0]      tmar;
	logic [8:0]       next_cnt;
	logic [8:0]       period;
	logic             period_end;
	logic [31:0]      tcrr_inc;
	logic             tcrr_full;
	logic             soft_rst;
	logic             is_tick;

	// Decode the beat and tap the fixed registers
	assign idx        = item_s1.reg_index[IDX_W-1:0];
	assign in_range   = ({1'b0, item_s1.reg_index} < 6'(STORE_WORDS));
	assign wv         = item_s1.wdata;
	assign ctl        = regs_q[I_TCLR];
	assign tcrr       = regs_q[I_TCRR];
	assign tldr       = regs_q[I_TLDR];
	assign tmar       = regs_q[I_TMAR];
	assign next_cnt   = {1'b0, count_q} + 9'd1;
	assign period     = 9'd1 << shift_q;
	assign period_end = (next_cnt >= period);
	assign tcrr_inc   = tcrr + 32'd1;
	assign tcrr_full  = (tcrr == 32'hFFFF_FFFF);
	assign soft_rst   = take && (item_s1.cmd == gpt_pkg::CMD_WRITE) &&
		(item_s1.reg_index == gpt_pkg::W_TIOCP) && item_s1.wdata[0];
	assign is_tick    = take && (item_s1.cmd == gpt_pkg::CMD_TICK);

	// Work out the next state and the read data
	always_comb begin
		logic [31:0] tcrr_nx;
		logic [1:0]  irq_set;

		regs_d  = regs_q;
		run_d   = run_q;
		shift_d = shift_q;
		count_d = count_q;
		rdata_d = '0;
		tcrr_nx = tcrr;
		irq_set = 2'b00;

		unique case (item_s1.cmd)
			gpt_pkg::CMD_READ: begin
				if (in_range) begin
					rdata_d = regs_q[idx];
				end
			end
			gpt_pkg::CMD_WRITE: begin
				unique case (item_s1.reg_index)
					gpt_pkg::W_TIOCP: begin
						if (wv[0]) begin
							for (int i = 0; i < STORE_WORDS; i++) begin
								regs_d[i] = '0;
							end
							regs_d[I_TIDR] = gpt_pkg::REVISION;
							run_d          = 1'b0;
							shift_d        = '0;
							count_d        = '0;
						end
						regs_d[I_TIOCP] = wv;
					end
					gpt_pkg::W_IRQSTAT: begin
						regs_d[I_IRQSTAT] = regs_q[I_IRQSTAT] & ~wv;
						regs_d[I_IRQRAW]  = regs_q[I_IRQRAW] & ~wv;
					end
					gpt_pkg::W_IENSET: begin
						regs_d[I_IENSET] = regs_q[I_IENSET] | wv;
					end
					gpt_pkg::W_IENCLR: begin
						regs_d[I_IENSET] = regs_q[I_IENSET] & ~wv;
					end
					gpt_pkg::W_TCLR: begin
						shift_d = wv[gpt_pkg::CTL_PRE] ? ({1'b0, wv[4:2]} + 4'd1) : 4'd0;
						if (wv[gpt_pkg::CTL_ST] && !run_q) begin
							run_d   = 1'b1;
							count_d = '0;
						end else if (!wv[gpt_pkg::CTL_ST] && run_q) begin
							run_d = 1'b0;
						end
						regs_d[I_TCLR] = wv;
					end
					gpt_pkg::W_TCRR: begin
						regs_d[I_TCRR] = wv;
						if (run_q) begin
							count_d = '0;
						end
					end
					gpt_pkg::W_TTGR: begin
						regs_d[I_TCRR] = tldr;
						if (run_q) begin
							count_d = '0;
						end
					end
					default: begin
						if (in_range) begin
							regs_d[idx] = wv;
						end
					end
				endcase
			end
			gpt_pkg::CMD_TICK: begin
				if (run_q) begin
					if (period_end) begin
						count_d = '0;
						if (tcrr_full) begin
							irq_set = gpt_pkg::IRQ_OVF;
							if (ctl[gpt_pkg::CTL_AR]) begin
								tcrr_nx = tldr;
							end else begin
								tcrr_nx = '0;
								run_d   = 1'b0;
							end
						end else begin
							tcrr_nx = tcrr_inc;
						end
					end else begin
						count_d = next_cnt[7:0];
					end
					if (ctl[gpt_pkg::CTL_CE] && (tcrr_nx >= tmar)) begin
						irq_set = irq_set | gpt_pkg::IRQ_MAT;
					end
					regs_d[I_TCRR]    = tcrr_nx;
					regs_d[I_IRQRAW]  = regs_q[I_IRQRAW] | {30'd0, irq_set};
					regs_d[I_IRQSTAT] = regs_q[I_IRQSTAT] | {30'd0, irq_set};
				end
			end
			gpt_pkg::CMD_NOP: begin
			end
		endcase
	end

	// Hold state; advance it when a beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_WORDS; i++) begin
				regs_q[i] <= (i == I_TIDR) ? gpt_pkg::REVISION : 32'd0;
			end
			run_q          <= 1'b0;
			shift_q        <= '0;
			count_q        <= '0;
		end else if (take) begin
			regs_q  <= regs_d;
			run_q   <= run_d;
			shift_q <= shift_d;
			count_q <= count_d;
		end
	end

	`GPT_ASSERT_NEXT(a_idle_holds, clk, arst_n, !take,
		$stable(run_q) && $stable(shift_q) && $stable(count_q))
	`GPT_ASSERT_NEXT(a_soft_rst_rev, clk, arst_n, soft_rst,
		(regs_q[I_TIDR] == gpt_pkg::REVISION) && !run_q && (count_q == 8'd0))
	`GPT_ASSERT_NEXT(a_stopped_tick, clk, arst_n, is_tick && !run_q,
		!run_q && $stable(regs_q[I_TCRR]) && $stable(count_q))

endmodule

@@ src/general_purpose_timer_regs_unit.sv @@
// A request beat moves from the input register to the response register, one
// beat per cycle; a full response register that is stalled backs up into the
// input register and then stalls the request side. Reset: arst_n clears all but
// the payload and read data registers at once, the revision word reads back its
// fixed value, and the timer is stopped; no clearing pass is needed.
// Top level of the timer register unit: input stage, state core, output stage
module general_purpose_timer_regs_unit #(
	parameter int unsigned REG_WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [4:0]  reg_index,
	input  logic [31:0] wdata,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] rdata
);

	logic           valid_s1;
	gpt_pkg::item_t item_s1;
	logic           out_ready;
	logic           take;
	logic [31:0]    rdata_d;

	// Move a beat from the input register to the response register
	assign take = valid_s1 && out_ready;

	gpt_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.reg_index (reg_index),
		.wdata     (wdata),
		.take      (take),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	gpt_core #(
		.REG_WORDS (REG_WORDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.item_s1 (item_s1),
		.rdata_d (rdata_d)
	);

	gpt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.rdata_d   (rdata_d),
		.ready     (out_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rdata     (rdata)
	);

endmodule

@@ test/tb_general_purpose_timer_regs_unit.sv @@
// Self-checking testbench for the timer register unit: directed and random beats, shadow timer
module tb_general_purpose_timer_regs_unit;

	localparam int unsigned FILE_WORDS = 32;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned BEATS_PER_PHASE = 380;
	localparam int unsigned DRAIN_CYCLES = 8;

	localparam logic [31:0] ST_BIT  = 32'd1 << gpt_pkg::CTL_ST;
	localparam logic [31:0] AR_BIT  = 32'd1 << gpt_pkg::CTL_AR;
	localparam logic [31:0] PRE_BIT = 32'd1 << gpt_pkg::CTL_PRE;
	localparam logic [31:0] CE_BIT  = 32'd1 << gpt_pkg::CTL_CE;
	localparam logic [31:0] PTV_MAX = 32'h7 << 2;
	localparam logic [31:0] SOFT_RESET_BIT = 32'h1;

	// Shadow copy of the timer and register file; holds the read data still due
	class timer_shadow;
		logic [31:0] words [FILE_WORDS];
		bit          running;
		logic [3:0]  shift;
		logic [7:0]  pcount;
		logic [31:0] rdata_due [$];
		int unsigned fails;

		function new();
			clear_state();
			fails = 0;
		endfunction

		function void clear_state();
			foreach (words[i]) words[i] = '0;
			words[gpt_pkg::W_TIDR] = gpt_pkg::REVISION;
			running = 0;
			shift = '0;
			pcount = '0;
		endfunction

		function void raise(logic [1:0] bits);
			words[gpt_pkg::W_IRQRAW] |= 32'(bits);
			words[gpt_pkg::W_IRQSTAT] |= 32'(bits);
		endfunction

		// Advance prescaler and counter by one functional clock
		function void tick();
			logic [31:0] ctl;
			int unsigned nxt;
			ctl = words[gpt_pkg::W_TCLR];
			if (!running) return;
			nxt = pcount + 1;
			if (nxt >= (32'd1 << shift)) begin
				pcount = '0;
				if (words[gpt_pkg::W_TCRR] == '1) begin
					raise(gpt_pkg::IRQ_OVF);
					if (ctl[gpt_pkg::CTL_AR]) begin
						words[gpt_pkg::W_TCRR] = words[gpt_pkg::W_TLDR];
					end else begin
						words[gpt_pkg::W_TCRR] = '0;
						running = 0;
					end
				end else begin
					words[gpt_pkg::W_TCRR] += 32'd1;
				end
			end else begin
				pcount = 8'(nxt);
			end
			if (ctl[gpt_pkg::CTL_CE] && words[gpt_pkg::W_TCRR] >= words[gpt_pkg::W_TMAR])
				raise(gpt_pkg::IRQ_MAT);
		endfunction

		function void write_word(logic [4:0] idx, logic [31:0] v);
			case (idx)
				gpt_pkg::W_TIOCP: begin
					if (v[0]) clear_state();
					words[gpt_pkg::W_TIOCP] = v;
				end
				gpt_pkg::W_IRQSTAT: begin
					words[gpt_pkg::W_IRQSTAT] &= ~v;
					words[gpt_pkg::W_IRQRAW] &= ~v;
				end
				gpt_pkg::W_IENSET: words[gpt_pkg::W_IENSET] |= v;
				gpt_pkg::W_IENCLR: words[gpt_pkg::W_IENSET] &= ~v;
				gpt_pkg::W_TCLR: begin
					shift = v[gpt_pkg::CTL_PRE] ? 4'(v[4:2]) + 4'd1 : 4'd0;
					if (v[gpt_pkg::CTL_ST] && !running) begin
						running = 1;
						pcount = '0;
					end else if (!v[gpt_pkg::CTL_ST] && running) begin
						running = 0;
					end
					words[gpt_pkg::W_TCLR] = v;
				end
				gpt_pkg::W_TCRR: begin
					words[gpt_pkg::W_TCRR] = v;
					if (running) pcount = '0;
				end
				gpt_pkg::W_TTGR: begin
					words[gpt_pkg::W_TCRR] = words[gpt_pkg::W_TLDR];
					if (running) pcount = '0;
				end
				default: if (idx < FILE_WORDS) words[idx] = v;
			endcase
		endfunction

		// Apply an accepted request beat and queue the read data it returns
		function void take_request(gpt_pkg::cmd_t c, logic [4:0] idx, logic [31:0] v);
			logic [31:0] rd;
			rd = '0;
			case (c)
				gpt_pkg::CMD_READ: if (idx < FILE_WORDS) rd = words[idx];
				gpt_pkg::CMD_WRITE: write_word(idx, v);
				gpt_pkg::CMD_TICK: tick();
				default: ;
			endcase
			rdata_due.push_back(rd);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			fails++;
		endtask

		// Compare a response beat with the oldest read data due
		task check_rdata(logic [31:0] got);
			logic [31:0] want;
			if (rdata_due.size() == 0) begin
				report($sformatf("response beat rdata=%h with nothing due", got));
			end else begin
				want = rdata_due.pop_front();
				if (got !== want) report($sformatf("rdata %h, expected %h", got, want));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  cmd;
	logic [4:0]  reg_index;
	logic [31:0] wdata;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [31:0] rdata;

	timer_shadow shadow;
	int unsigned beats_sent;
	int unsigned quiet_cycles;
	int unsigned idle_pct;
	int unsigned stall_pct;

	general_purpose_timer_regs_unit #(
		.REG_WORDS(FILE_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.reg_index(reg_index),
		.wdata(wdata),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rdata(rdata)
	);

	always #2 clk = ~clk;

	// Stall the response side at random
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watch both channels, check responses and bound quiet stretches
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				shadow.take_request(gpt_pkg::cmd_t'(cmd), reg_index, wdata);
			if (rsp_valid && !rsp_stall) shadow.check_rdata(rdata);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Drive one request beat, with random idle cycles ahead of it
	task automatic send_beat(input gpt_pkg::cmd_t c, input logic [4:0] idx,
		input logic [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= c;
		reg_index <= idx;
		wdata <= v;
		do @(posedge clk); while (req_stall);
		beats_sent++;
	endtask

	function automatic logic [31:0] near_top();
		if ($urandom_range(9) < 8) return 32'hFFFF_FFFF - $urandom_range(0, 24);
		return $urandom();
	endfunction

	// Control word: mostly running, prescaler mostly off or short
	function automatic logic [31:0] control_word();
		logic [31:0] v;
		v = $urandom();
		v[gpt_pkg::CTL_ST] = ($urandom_range(99) < 85);
		v[gpt_pkg::CTL_PRE] = ($urandom_range(99) < 25);
		if ($urandom_range(3) != 0) v[4:2] = 3'($urandom_range(0, 1));
		return v;
	endfunction

	// Load registers, start the timer, then run ticks mixed with reads and control changes
	task automatic run_sequence();
		int unsigned n;
		n = $urandom_range(8, 30);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TLDR, near_top());
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TMAR, near_top());
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_IENSET, $urandom());
		send_beat(gpt_pkg::CMD_WRITE,
			$urandom_range(1) ? gpt_pkg::W_TCRR : gpt_pkg::W_TTGR, near_top());
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TCLR, control_word());
		repeat (n) begin
			case ($urandom_range(11))
				0: send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_TCRR, $urandom());
				1: send_beat(gpt_pkg::CMD_READ,
					$urandom_range(1) ? gpt_pkg::W_IRQSTAT : gpt_pkg::W_IRQRAW, $urandom());
				2: send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TCLR, control_word());
				3: send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TCRR, near_top());
				default: send_beat(gpt_pkg::CMD_TICK, 5'($urandom()), $urandom());
			endcase
		end
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_IRQRAW, $urandom());
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_IRQSTAT, $urandom());
	endtask

	// Any command, any index, any data
	task automatic random_beat();
		send_beat(gpt_pkg::cmd_t'($urandom_range(3)), 5'($urandom()), $urandom());
	endtask

	task automatic directed_beats();
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_TIDR, '1);
		send_beat(gpt_pkg::CMD_TICK, gpt_pkg::W_TCRR, '0);
		send_beat(gpt_pkg::CMD_NOP, gpt_pkg::W_TIDR, '1);
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_TCRR, '0);
		// enable masks and the unstored clear word
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_IENSET, '1);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_IENCLR, 32'h5555_5555);
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_IENSET, '0);
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_IENCLR, '0);
		// auto-reload overflow with compare
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TLDR, 32'hFFFF_FFFE);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TMAR, '0);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TCRR, 32'hFFFF_FFFE);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TCLR, ST_BIT | AR_BIT | CE_BIT);
		repeat (3) send_beat(gpt_pkg::CMD_TICK, gpt_pkg::W_TIDR, '0);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_IRQSTAT, 32'(gpt_pkg::IRQ_MAT));
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_IRQRAW, '0);
		// one-shot overflow stops at zero, then a stopped tick
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TCLR, ST_BIT);
		repeat (2) send_beat(gpt_pkg::CMD_TICK, gpt_pkg::W_TIDR, '0);
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_TCRR, '0);
		// slowest prescaler, trigger reload, then soft reset
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TCLR, ST_BIT | PRE_BIT | PTV_MAX);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TTGR, '1);
		send_beat(gpt_pkg::CMD_TICK, gpt_pkg::W_TIDR, '0);
		send_beat(gpt_pkg::CMD_WRITE, 5'(FILE_WORDS - 1), '1);
		send_beat(gpt_pkg::CMD_WRITE, gpt_pkg::W_TIOCP, SOFT_RESET_BIT);
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_TIOCP, '0);
		send_beat(gpt_pkg::CMD_READ, gpt_pkg::W_TCLR, '0);
		send_beat(gpt_pkg::CMD_READ, 5'(FILE_WORDS - 1), '0);
	endtask

	initial begin
		int unsigned idle_of [4];
		int unsigned stall_of [4];
		idle_of = '{0, 61, 0, 29};
		stall_of = '{0, 0, 61, 29};
		shadow = new();
		beats_sent = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = gpt_pkg::CMD_NOP;
		reg_index = '0;
		wdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Step through the idle and response stall phases
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_of[p];
			stall_pct = stall_of[p];
			if (p == 0) directed_beats();
			while (beats_sent < (p + 1) * BEATS_PER_PHASE) begin
				if ($urandom_range(9) < 7) begin
					run_sequence();
				end else begin
					random_beat();
				end
			end
		end
		req_valid <= 1'b0;

		// Drain outstanding responses once the last request is on record
		@(posedge clk);
		while (shadow.rdata_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/gpt_pkg.sv
src/gpt_in_stage.sv
src/gpt_out_stage.sv
src/gpt_core.sv
src/general_purpose_timer_regs_unit.sv
test/tb_general_purpose_timer_regs_unit.sv
